// ===== rtl/hsf_pkg.sv =====
// ----------------------------------------------------------------------------
// hsf_pkg: shared types and constants of the horizontal area shrink filter
// Pixel words, lane control, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
package hsf_pkg;

   localparam int CSR_WIDTH_W = 13;                // width register size
   localparam int CSR_INDEX_W = 1;
   localparam int STEP_W      = 27;                // 13.14 step, up to 8191 * 0x4000
   localparam int COV_W       = STEP_W + 2;        // signed coverage counter
   localparam int RECIP_W     = 16;
   localparam int SUM_W       = 16;
   localparam int PIX_W       = 8;
   localparam int LANES       = 4;
   localparam int FRAC_W      = 16;                // straddle multiplier width
   localparam int DIV_W       = 31;                // dividend and quotient width
   localparam int DIV_CNT_W   = $clog2(DIV_W);
   localparam int UNIT_VAL    = 32'h0000_4000;
   localparam int RECIP_NUM   = 32'h4000_0000;

   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_WIDTH = 1'b1;

   localparam logic [CSR_WIDTH_W-1:0] SRC_RESET   = 13'd2;
   localparam logic [CSR_WIDTH_W-1:0] DST_RESET   = 13'd1;
   localparam logic [STEP_W-1:0]      STEP_RESET  = 27'h000_8000;
   localparam logic [RECIP_W-1:0]     RECIP_RESET = 16'h8000;
   localparam logic [RECIP_W-1:0]     RECIP_ZERO  = 16'hFFFF;

   localparam logic signed [COV_W-1:0] COV_UNIT = COV_W'(UNIT_VAL);

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
      logic [PIX_W-1:0] alpha_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
      logic [PIX_W-1:0] alpha_out;
   } rsp_type;

   typedef struct packed {
      logic accept;     // pixel word taken this cycle
      logic straddle;   // pixel closes a destination pixel
      logic clear;      // restart the row
      logic b_load;     // move total into the output register
   } lane_ctl_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_DIV_STEP,
      SEQ_DIV_RECIP
   } seq_state_type;

endpackage

// ===== rtl/horizontal_area_shrink_filter_top.sv =====
// ----------------------------------------------------------------------------
// horizontal_area_shrink_filter_top: horizontal area-averaging row shrink
// Four channel lanes, coverage control, step sequencer and result merge.
// ----------------------------------------------------------------------------
// One RGBA pixel word is taken per cycle while the sequencer is idle and the
// pipeline can move; a closing pixel loads the lane totals, which then pass to
// the output register. A held result does not stop the next pixel until a
// second result queues behind it. A write to either width register starts a
// recompute of the 13.14 step and its reciprocal in two passes of the shared
// one-bit-per-cycle divider, with req_ready low throughout. A write also
// restarts the row, as does every src_width-th pixel.
module horizontal_area_shrink_filter_top #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hsf_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hsf_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [hsf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hsf_pkg::CSR_WIDTH_W-1:0]     csr_wdata
);

   localparam int CW = hsf_pkg::CSR_WIDTH_W;
   localparam logic [CW-1:0] WIDTH_CAP =
      (MAX_WIDTH >= (2 ** CW) - 1) ? {CW{1'b1}} : CW'(MAX_WIDTH);

   hsf_pkg::seq_state_type          state_ff, state_in;
   logic [CW-1:0]                   src_ff, src_in;
   logic [CW-1:0]                   dst_ff, dst_in;
   logic [hsf_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [hsf_pkg::RECIP_W-1:0]     recip_ff, recip_in;
   logic signed [hsf_pkg::COV_W-1:0] cov_ff, cov_in;
   logic [CW-1:0]                   col_ff, col_in;
   logic                            valid_a_ff, valid_a_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic                            cfg_hit;
   logic [CW-1:0]                   src_eff, dst_eff;
   logic                            div_start, div_sel_recip, div_done;
   logic                            step_cap, recip_cap, busy;
   logic [hsf_pkg::DIV_W-1:0]       div_numer, div_quot;
   logic [hsf_pkg::STEP_W-1:0]      div_denom;
   logic                            b_move, a_free, accept, straddle, row_end;
   logic [CW:0]                     col_next;
   logic signed [hsf_pkg::COV_W-1:0] step_s, frac;
   hsf_pkg::lane_ctl_type           lane_ctl;
   logic [hsf_pkg::PIX_W-1:0]       lane_px  [hsf_pkg::LANES];
   logic [hsf_pkg::PIX_W-1:0]       lane_res [hsf_pkg::LANES];

   // configuration writes and effective widths
   always_comb begin
      cfg_hit = 1'b0;
      src_in  = src_ff;
      dst_in  = dst_ff;
      if (csr_we) begin
         case (csr_index)
            hsf_pkg::CSR_SRC_WIDTH: begin
               src_in  = csr_wdata;
               cfg_hit = 1'b1;
            end
            hsf_pkg::CSR_DST_WIDTH: begin
               dst_in  = csr_wdata;
               cfg_hit = 1'b1;
            end
            default: cfg_hit = 1'b0;
         endcase
      end
      src_eff = (32'(src_in) > MAX_WIDTH) ? WIDTH_CAP : src_in;
      dst_eff = (32'(dst_in) > MAX_WIDTH) ? WIDTH_CAP : dst_in;
      if (dst_eff == '0) begin
         dst_eff = CW'(1);
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hsf_pkg::SEQ_IDLE: begin
            if (cfg_hit) state_in = hsf_pkg::SEQ_DIV_STEP;
         end
         hsf_pkg::SEQ_DIV_STEP: begin
            if (cfg_hit) state_in = hsf_pkg::SEQ_DIV_STEP;
            else if (div_done) state_in = hsf_pkg::SEQ_DIV_RECIP;
         end
         hsf_pkg::SEQ_DIV_RECIP: begin
            if (cfg_hit) state_in = hsf_pkg::SEQ_DIV_STEP;
            else if (div_done) state_in = hsf_pkg::SEQ_IDLE;
         end
         default: state_in = hsf_pkg::SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      div_start     = 1'b0;
      div_sel_recip = 1'b0;
      step_cap      = 1'b0;
      recip_cap     = 1'b0;
      busy          = 1'b1;
      case (state_ff)
         hsf_pkg::SEQ_IDLE: begin
            busy      = 1'b0;
            div_start = cfg_hit;
         end
         hsf_pkg::SEQ_DIV_STEP: begin
            div_start     = cfg_hit || div_done;
            div_sel_recip = !cfg_hit;
            step_cap      = !cfg_hit && div_done;
         end
         hsf_pkg::SEQ_DIV_RECIP: begin
            div_start = cfg_hit;
            recip_cap = !cfg_hit && div_done;
         end
         default: busy = 1'b1;
      endcase
   end

   always_comb begin
      if (div_sel_recip) begin
         div_numer = hsf_pkg::DIV_W'(hsf_pkg::RECIP_NUM);
         div_denom = div_quot[hsf_pkg::STEP_W-1:0];
      end else begin
         div_numer = hsf_pkg::DIV_W'({src_eff, 14'b0});
         div_denom = hsf_pkg::STEP_W'(dst_eff);
      end
      step_in  = step_cap ? div_quot[hsf_pkg::STEP_W-1:0] : step_ff;
      recip_in = recip_ff;
      if (recip_cap) begin
         recip_in = (step_ff == '0) ? hsf_pkg::RECIP_ZERO
                                    : div_quot[hsf_pkg::RECIP_W-1:0];
      end
   end

   hsf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   // handshake and coverage control
   always_comb begin
      b_move    = !rsp_valid_ff || rsp_ready;
      a_free    = !valid_a_ff || b_move;
      req_ready = !busy && a_free;
      accept    = req_valid && req_ready;
      straddle  = (cov_ff <= hsf_pkg::COV_UNIT);
      col_next  = {1'b0, col_ff} + 1'b1;
      // row length follows the current source width
      row_end   = (col_next >= {1'b0, ((32'(src_ff) > MAX_WIDTH) ? WIDTH_CAP : src_ff)});
      step_s    = $signed({2'b00, step_ff});
      frac      = hsf_pkg::COV_UNIT - cov_ff;

      cov_in = cov_ff;
      col_in = col_ff;
      if (step_cap) begin
         cov_in = $signed({2'b00, div_quot[hsf_pkg::STEP_W-1:0]});
      end else if (accept) begin
         if (row_end) cov_in = step_s;
         else if (straddle) cov_in = step_s - frac;
         else cov_in = cov_ff - hsf_pkg::COV_UNIT;
      end
      if (cfg_hit || (accept && row_end)) begin
         col_in = '0;
      end else if (accept) begin
         col_in = col_next[CW-1:0];
      end

      valid_a_in   = (accept && straddle) ? 1'b1 : (b_move ? 1'b0 : valid_a_ff);
      rsp_valid_in = (valid_a_ff && b_move) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      lane_ctl.accept   = accept;
      lane_ctl.straddle = straddle;
      lane_ctl.clear    = cfg_hit || (accept && row_end);
      lane_ctl.b_load   = valid_a_ff && b_move;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hsf_pkg::SEQ_IDLE;
         src_ff       <= hsf_pkg::SRC_RESET;
         dst_ff       <= hsf_pkg::DST_RESET;
         step_ff      <= hsf_pkg::STEP_RESET;
         recip_ff     <= hsf_pkg::RECIP_RESET;
         cov_ff       <= $signed({2'b00, hsf_pkg::STEP_RESET});
         col_ff       <= '0;
         valid_a_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         step_ff      <= step_in;
         recip_ff     <= recip_in;
         cov_ff       <= cov_in;
         col_ff       <= col_in;
         valid_a_ff   <= valid_a_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign lane_px[0] = req_data.red_in;
   assign lane_px[1] = req_data.green_in;
   assign lane_px[2] = req_data.blue_in;
   assign lane_px[3] = req_data.alpha_in;

   for (genvar i = 0; i < hsf_pkg::LANES; i++) begin : g_lane
      hsf_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .px    (lane_px[i]),
         .mc    (cov_ff[hsf_pkg::FRAC_W-1:0]),
         .mf    (frac[hsf_pkg::FRAC_W-1:0]),
         .recip (recip_ff),
         .res   (lane_res[i])
      );
   end

   // merge the lane results into one output word
   assign rsp_data.red_out   = lane_res[0];
   assign rsp_data.green_out = lane_res[1];
   assign rsp_data.blue_out  = lane_res[2];
   assign rsp_data.alpha_out = lane_res[3];
   assign rsp_valid          = rsp_valid_ff;

endmodule

// ===== rtl/hsf_div.sv =====
// ----------------------------------------------------------------------------
// hsf_div: iterative restoring divider
// Produces one quotient bit per cycle; shared by the step and reciprocal passes.
// ----------------------------------------------------------------------------
module hsf_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [hsf_pkg::DIV_W-1:0]         numer,
   input  logic [hsf_pkg::STEP_W-1:0]        denom,
   output logic                              done,
   output logic [hsf_pkg::DIV_W-1:0]         quot
);

   localparam logic [hsf_pkg::DIV_CNT_W-1:0] LAST = hsf_pkg::DIV_CNT_W'(hsf_pkg::DIV_W - 1);

   logic                              run_ff, run_in;
   logic                              done_ff, done_in;
   logic [hsf_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [hsf_pkg::DIV_W-1:0]         num_ff, num_in;
   logic [hsf_pkg::STEP_W-1:0]        rem_ff, rem_in;
   logic [hsf_pkg::STEP_W-1:0]        den_ff, den_in;
   logic [hsf_pkg::STEP_W:0]          trial;
   logic [hsf_pkg::STEP_W:0]          diff;
   logic                              ge;

   always_comb begin
      trial = {rem_ff, num_ff[hsf_pkg::DIV_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         num_in = numer;
         rem_in = '0;
         den_in = denom;
      end else if (run_ff) begin
         // shift in one dividend bit, subtract when it fits
         rem_in = ge ? diff[hsf_pkg::STEP_W-1:0] : trial[hsf_pkg::STEP_W-1:0];
         num_in = {num_ff[hsf_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// ===== rtl/hsf_lane.sv =====
// ----------------------------------------------------------------------------
// hsf_lane: one color channel of the shrink filter
// Keeps the channel sum, splits straddling pixels and scales the closed total.
// ----------------------------------------------------------------------------
module hsf_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  hsf_pkg::lane_ctl_type          ctl,
   input  logic [hsf_pkg::PIX_W-1:0]      px,
   input  logic [hsf_pkg::FRAC_W-1:0]     mc,
   input  logic [hsf_pkg::FRAC_W-1:0]     mf,
   input  logic [hsf_pkg::RECIP_W-1:0]    recip,
   output logic [hsf_pkg::PIX_W-1:0]      res
);

   localparam int SH_W = hsf_pkg::PIX_W + 2;
   localparam int PR_W = SH_W + hsf_pkg::FRAC_W;
   localparam int SC_W = hsf_pkg::SUM_W + hsf_pkg::RECIP_W;

   logic [hsf_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [hsf_pkg::SUM_W-1:0]   tot_ff, tot_in;
   logic [hsf_pkg::PIX_W-1:0]   res_ff, res_in;
   logic [SH_W-1:0]             shifted;
   logic [PR_W-1:0]             part_prod;
   logic [PR_W-1:0]             seed_prod;
   logic [SC_W-1:0]             scale_prod;
   logic [hsf_pkg::SUM_W-1:0]   scaled;

   always_comb begin
      shifted   = {px, 2'b00};
      part_prod = PR_W'(shifted) * PR_W'(mc);
      seed_prod = PR_W'(shifted) * PR_W'(mf);
      tot_in    = sum_ff + hsf_pkg::SUM_W'(part_prod[PR_W-1:hsf_pkg::FRAC_W]);
      sum_in    = sum_ff;
      if (ctl.clear) begin
         sum_in = '0;
      end else if (ctl.accept) begin
         if (ctl.straddle) begin
            // seed the next destination pixel with the leftover part
            sum_in = hsf_pkg::SUM_W'(seed_prod[PR_W-1:hsf_pkg::FRAC_W]);
         end else begin
            sum_in = sum_ff + hsf_pkg::SUM_W'(px);
         end
      end
      scale_prod = SC_W'(tot_ff) * SC_W'(recip);
      scaled     = scale_prod[SC_W-1:hsf_pkg::RECIP_W];
      // clamp as a signed value to one byte
      if (scaled[hsf_pkg::SUM_W-1]) begin
         res_in = '0;
      end else if (scaled > hsf_pkg::SUM_W'(8'hFF)) begin
         res_in = '1;
      end else begin
         res_in = scaled[hsf_pkg::PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
      if (ctl.accept && ctl.straddle) begin
         tot_ff <= tot_in;
      end
      if (ctl.b_load) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule
